FILE: rtl/gcsd_pkg.sv
// shared types, constants and helpers of the gnss cycle-slip detector
package gcsd_pkg;

	localparam int SAT_SLOTS  = 64;
	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS  = 16;

	localparam int VAL_W      = 48;
	localparam int GAP_W      = 21;
	localparam int SAT_W      = 6;
	localparam int SYS_W      = 2;
	localparam int EPOCH_W    = 16;
	localparam int LIM_W      = 20;
	localparam int MAXGAP_W   = 16;
	localparam int ARC_W      = COUNT_BITS;
	localparam int OUT_ARC_W  = 16;
	localparam int SLOTS      = 2 * SAT_SLOTS;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int COEF_W     = 36;
	localparam int CHUNK_W    = VAL_W / 2;
	localparam int PROD_W     = CHUNK_W + COEF_W;
	localparam int FULL_W     = PROD_W + CHUNK_W;
	localparam int TERM_W     = FULL_W - 32;
	localparam int ACC_W      = TERM_W + 3;
	localparam int DVD_W      = ((LIM_W > ARC_W) ? LIM_W : ARC_W) + 1;

	localparam int NUM_PRODUCTS = 10;
	localparam int STEP_W       = $clog2(2 * NUM_PRODUCTS + 3);
	localparam int FINAL_STEP   = 2 * NUM_PRODUCTS + 2;

	localparam logic [SYS_W-1:0] SYS_GPS = 2'd0;
	localparam logic [SYS_W-1:0] SYS_BDS = 2'd1;

	localparam logic [ARC_W-1:0] ARC_MAX = '1;

	// register reset values, capped to the register width
	localparam longint WL_RAW = longint'(3) << (FRAC_BITS - 1);
	localparam longint GF_RAW = longint'(1) << (FRAC_BITS - 1);
	localparam logic [LIM_W-1:0] WL_LIMIT_RESET =
		(WL_RAW > 64'hFFFFF) ? 20'hFFFFF : LIM_W'(WL_RAW);
	localparam logic [LIM_W-1:0] GF_LIMIT_RESET =
		(GF_RAW > 64'hFFFFF) ? 20'hFFFFF : LIM_W'(GF_RAW);
	localparam logic [MAXGAP_W-1:0] MAX_GAP_RESET = 16'd1100;

	// q32 combination coefficients, rounded half up
	localparam logic [63:0] LIGHT   = 64'd299792458;
	localparam logic [63:0] Q32_ONE = 64'd4294967296;

	localparam logic [63:0] DEN_WL_GPS = 64'd10230000 * 64'd34;
	localparam logic [63:0] DEN_G1_GPS = 64'd10230000 * 64'd154;
	localparam logic [63:0] DEN_G2_GPS = 64'd10230000 * 64'd120;
	localparam logic [63:0] DEN_WL_BDS = 64'd2046000 * 64'd143;
	localparam logic [63:0] DEN_G1_BDS = 64'd2046000 * 64'd763;
	localparam logic [63:0] DEN_G2_BDS = 64'd2046000 * 64'd620;

	localparam logic [COEF_W-1:0] CK_WL_GPS =
		COEF_W'((LIGHT * Q32_ONE + DEN_WL_GPS / 2) / DEN_WL_GPS);
	localparam logic [COEF_W-1:0] CK_N1_GPS =
		COEF_W'((64'd154 * Q32_ONE + 64'd274 / 2) / 64'd274);
	localparam logic [COEF_W-1:0] CK_N2_GPS =
		COEF_W'((64'd120 * Q32_ONE + 64'd274 / 2) / 64'd274);
	localparam logic [COEF_W-1:0] CK_G1_GPS =
		COEF_W'((LIGHT * Q32_ONE + DEN_G1_GPS / 2) / DEN_G1_GPS);
	localparam logic [COEF_W-1:0] CK_G2_GPS =
		COEF_W'((LIGHT * Q32_ONE + DEN_G2_GPS / 2) / DEN_G2_GPS);
	localparam logic [COEF_W-1:0] CK_K1_GPS =
		COEF_W'((64'd23716 * Q32_ONE + 64'd9316 / 2) / 64'd9316);
	localparam logic [COEF_W-1:0] CK_K2_GPS =
		COEF_W'((64'd14400 * Q32_ONE + 64'd9316 / 2) / 64'd9316);

	localparam logic [COEF_W-1:0] CK_WL_BDS =
		COEF_W'((LIGHT * Q32_ONE + DEN_WL_BDS / 2) / DEN_WL_BDS);
	localparam logic [COEF_W-1:0] CK_N1_BDS =
		COEF_W'((64'd763 * Q32_ONE + 64'd1383 / 2) / 64'd1383);
	localparam logic [COEF_W-1:0] CK_N2_BDS =
		COEF_W'((64'd620 * Q32_ONE + 64'd1383 / 2) / 64'd1383);
	localparam logic [COEF_W-1:0] CK_G1_BDS =
		COEF_W'((LIGHT * Q32_ONE + DEN_G1_BDS / 2) / DEN_G1_BDS);
	localparam logic [COEF_W-1:0] CK_G2_BDS =
		COEF_W'((LIGHT * Q32_ONE + DEN_G2_BDS / 2) / DEN_G2_BDS);
	localparam logic [COEF_W-1:0] CK_K1_BDS =
		COEF_W'((64'd582169 * Q32_ONE + 64'd197769 / 2) / 64'd197769);
	localparam logic [COEF_W-1:0] CK_K2_BDS =
		COEF_W'((64'd384400 * Q32_ONE + 64'd197769 / 2) / 64'd197769);

	typedef enum logic [2:0] {
		OUT_OK          = 3'd0,
		OUT_ARC_START   = 3'd1,
		OUT_MISSING     = 3'd2,
		OUT_UNSUPPORTED = 3'd3,
		OUT_NEW_SAT     = 3'd4,
		OUT_GAP         = 3'd5,
		OUT_SLIP        = 3'd6
	} outcome_t;

	typedef enum logic [1:0] {
		REG_WL_LIMIT = 2'd0,
		REG_GF_LIMIT = 2'd1,
		REG_MAX_GAP  = 2'd2
	} reg_idx_t;

	// product order of the combination sequencer
	typedef enum logic [3:0] {
		PR_L1_WL = 4'd0,
		PR_L2_WL = 4'd1,
		PR_P1_N1 = 4'd2,
		PR_P2_N2 = 4'd3,
		PR_L1_G1 = 4'd4,
		PR_L2_G2 = 4'd5,
		PR_P1_K1 = 4'd6,
		PR_P2_K2 = 4'd7,
		PR_L1_K1 = 4'd8,
		PR_L2_K2 = 4'd9
	} prod_t;

	typedef enum logic [2:0] {
		UPD_IDLE,
		UPD_READ,
		UPD_DIV,
		UPD_MEAN,
		UPD_WRITE
	} upd_state_t;

	typedef struct packed {
		logic [LIM_W-1:0]    widelane_jump_limit;
		logic [LIM_W-1:0]    gf_jump_limit;
		logic [MAXGAP_W-1:0] max_epoch_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic                    first_of_epoch;
		logic [SYS_W-1:0]        gnss_system;
		logic [SAT_W-1:0]        sat_number;
		logic                    missing;
		logic signed [GAP_W-1:0] epoch_gap_ms;
		logic signed [VAL_W-1:0] mw;
		logic signed [VAL_W-1:0] gf;
		logic signed [VAL_W-1:0] ifc;
		logic signed [VAL_W-1:0] ifp;
	} comb_t;

	typedef struct packed {
		logic [EPOCH_W-1:0]      tag;
		logic [ARC_W-1:0]        arc;
		logic signed [VAL_W-1:0] smooth;
		logic signed [VAL_W-1:0] gf;
	} entry_t;

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-VAL_W:0] top;
		top = v[ACC_W-1:VAL_W-1];
		if ((&top) || !(|top))
			return v[VAL_W-1:0];
		else if (v[ACC_W-1])
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

endpackage

FILE: rtl/gcsd_ifs.sv
// observation and result channel interfaces
interface gcsd_obs_if import gcsd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    first_of_epoch;
	logic [SYS_W-1:0]        gnss_system;
	logic [SAT_W-1:0]        sat_number;
	logic signed [VAL_W-1:0] code_range_1;
	logic signed [VAL_W-1:0] code_range_2;
	logic signed [VAL_W-1:0] carrier_phase_1;
	logic signed [VAL_W-1:0] carrier_phase_2;
	logic signed [GAP_W-1:0] epoch_gap_ms;

	modport source(output valid, first_of_epoch, gnss_system, sat_number, code_range_1,
		code_range_2, carrier_phase_1, carrier_phase_2, epoch_gap_ms, input ready);
	modport sink(input valid, first_of_epoch, gnss_system, sat_number, code_range_1,
		code_range_2, carrier_phase_1, carrier_phase_2, epoch_gap_ms, output ready);
endinterface

interface gcsd_res_if import gcsd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    usable;
	logic [2:0]              outcome;
	logic signed [VAL_W-1:0] smoothed_widelane;
	logic signed [VAL_W-1:0] geometry_free_phase;
	logic signed [VAL_W-1:0] iono_free_code;
	logic signed [VAL_W-1:0] iono_free_phase;
	logic [OUT_ARC_W-1:0]    arc_length;

	modport source(output valid, usable, outcome, smoothed_widelane, geometry_free_phase,
		iono_free_code, iono_free_phase, arc_length, input ready);
	modport sink(input valid, usable, outcome, smoothed_widelane, geometry_free_phase,
		iono_free_code, iono_free_phase, arc_length, output ready);
endinterface

FILE: rtl/gcsd_ram.sv
// generic single-port-write ram with registered read
module gcsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/gcsd_comb.sv
// combination unit: forms mw, gf and iono-free values with one shared 24x36 multiplier
module gcsd_comb import gcsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gcsd_obs_if.sink   obs,
	output logic       comb_valid,
	input  logic       comb_ready,
	output comb_t      comb_data
);

	logic                    busy_q;
	logic [STEP_W-1:0]       step_q;
	logic                    first_q;
	logic [SYS_W-1:0]        sys_q;
	logic [SAT_W-1:0]        sat_q;
	logic                    missing_q;
	logic signed [GAP_W-1:0] gap_q;
	logic signed [VAL_W-1:0] p1_q, p2_q, l1_q, l2_q;

	logic [PROD_W-1:0]       prod_s1;
	logic                    prod_v_s1;
	prod_t                   prod_j_s1;
	logic                    prod_h_s1;
	logic                    prod_neg_s1;
	logic [PROD_W-1:0]       lo_q;

	logic [TERM_W-1:0]       term_s2;
	logic                    term_v_s2;
	prod_t                   term_j_s2;
	logic                    term_neg_s2;

	logic signed [ACC_W-1:0] acc_mw_q, acc_gf_q, acc_ifc_q, acc_ifp_q;

	logic                    out_valid_q;
	comb_t                   out_q;

	prod_t                   j;
	logic                    h;
	logic                    issue;
	logic                    bds;
	logic signed [VAL_W-1:0] op;
	logic [COEF_W-1:0]       coef;
	logic [VAL_W-1:0]        ua;
	logic [CHUNK_W-1:0]      chunk;
	logic [FULL_W-1:0]       full;
	logic                    sub;
	logic signed [ACC_W-1:0] t_mag, t_signed;
	logic                    accept, load;

	assign accept   = obs.valid && obs.ready;
	assign obs.ready = !busy_q;
	assign load     = busy_q && (step_q == STEP_W'(FINAL_STEP)) && (!out_valid_q || comb_ready);

	assign j     = prod_t'(step_q[STEP_W-1:1]);
	assign h     = step_q[0];
	assign issue = busy_q && (step_q < STEP_W'(2 * NUM_PRODUCTS));
	assign bds   = (sys_q == SYS_BDS);

	always_comb begin
		case (j)
			PR_L1_WL: begin op = l1_q; coef = bds ? CK_WL_BDS : CK_WL_GPS; end
			PR_L2_WL: begin op = l2_q; coef = bds ? CK_WL_BDS : CK_WL_GPS; end
			PR_P1_N1: begin op = p1_q; coef = bds ? CK_N1_BDS : CK_N1_GPS; end
			PR_P2_N2: begin op = p2_q; coef = bds ? CK_N2_BDS : CK_N2_GPS; end
			PR_L1_G1: begin op = l1_q; coef = bds ? CK_G1_BDS : CK_G1_GPS; end
			PR_L2_G2: begin op = l2_q; coef = bds ? CK_G2_BDS : CK_G2_GPS; end
			PR_P1_K1: begin op = p1_q; coef = bds ? CK_K1_BDS : CK_K1_GPS; end
			PR_P2_K2: begin op = p2_q; coef = bds ? CK_K2_BDS : CK_K2_GPS; end
			PR_L1_K1: begin op = l1_q; coef = bds ? CK_K1_BDS : CK_K1_GPS; end
			PR_L2_K2: begin op = l2_q; coef = bds ? CK_K2_BDS : CK_K2_GPS; end
			default:  begin op = '0;   coef = '0; end
		endcase
		ua    = op[VAL_W-1] ? VAL_W'(-op) : VAL_W'(op);
		chunk = h ? ua[VAL_W-1:CHUNK_W] : ua[CHUNK_W-1:0];
	end

	// rounding of the magnitude product to q0, then sign and sum
	always_comb begin
		full     = {prod_s1, {CHUNK_W{1'b0}}} + FULL_W'(lo_q) + FULL_W'(64'h80000000);
		t_mag    = $signed({3'b000, term_s2});
		case (term_j_s2) inside
			PR_L2_WL, PR_P1_N1, PR_P2_N2, PR_L2_G2, PR_P2_K2, PR_L2_K2: sub = 1'b1;
			default: sub = 1'b0;
		endcase
		t_signed = (term_neg_s2 ^ sub) ? -t_mag : t_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			prod_v_s1   <= 1'b0;
			term_v_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (load) begin
				busy_q <= 1'b0;
			end else if (busy_q && step_q != STEP_W'(FINAL_STEP)) begin
				step_q <= step_q + 1'b1;
			end
			prod_v_s1 <= issue;
			term_v_s2 <= prod_v_s1 && prod_h_s1;
			if (load)
				out_valid_q <= 1'b1;
			else if (comb_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q   <= obs.first_of_epoch;
			sys_q     <= obs.gnss_system;
			sat_q     <= obs.sat_number;
			gap_q     <= obs.epoch_gap_ms;
			p1_q      <= obs.code_range_1;
			p2_q      <= obs.code_range_2;
			l1_q      <= obs.carrier_phase_1;
			l2_q      <= obs.carrier_phase_2;
			missing_q <= (obs.code_range_1 == '0) || (obs.code_range_2 == '0) ||
				(obs.carrier_phase_1 == '0) || (obs.carrier_phase_2 == '0);
			acc_mw_q  <= '0;
			acc_gf_q  <= '0;
			acc_ifc_q <= '0;
			acc_ifp_q <= '0;
		end else if (term_v_s2) begin
			case (term_j_s2) inside
				PR_L1_WL, PR_L2_WL, PR_P1_N1, PR_P2_N2: acc_mw_q  <= acc_mw_q + t_signed;
				PR_L1_G1, PR_L2_G2:                     acc_gf_q  <= acc_gf_q + t_signed;
				PR_P1_K1, PR_P2_K2:                     acc_ifc_q <= acc_ifc_q + t_signed;
				default:                                acc_ifp_q <= acc_ifp_q + t_signed;
			endcase
		end

		prod_s1     <= PROD_W'(chunk) * PROD_W'(coef);
		prod_j_s1   <= j;
		prod_h_s1   <= h;
		prod_neg_s1 <= op[VAL_W-1];

		if (prod_v_s1 && !prod_h_s1)
			lo_q <= prod_s1;
		term_s2     <= full[FULL_W-1:32];
		term_j_s2   <= prod_j_s1;
		term_neg_s2 <= prod_neg_s1;

		if (load) begin
			out_q.first_of_epoch <= first_q;
			out_q.gnss_system    <= sys_q;
			out_q.sat_number     <= sat_q;
			out_q.missing        <= missing_q;
			out_q.epoch_gap_ms   <= gap_q;
			out_q.mw             <= sat_val(acc_mw_q);
			out_q.gf             <= sat_val(acc_gf_q);
			out_q.ifc            <= sat_val(acc_ifc_q);
			out_q.ifp            <= sat_val(acc_ifp_q);
		end
	end

	assign comb_valid = out_valid_q;
	assign comb_data  = out_q;

endmodule

FILE: rtl/gcsd_update.sv
// satellite table update: read, classify, divide for the running mean, write back
module gcsd_update import gcsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  comb_t        in_data,
	input  cfg_t         cfg,
	gcsd_res_if.source   res
);

	upd_state_t              state_q, state_d;
	comb_t                   item_q;
	logic [EPOCH_W-1:0]      epoch_q;
	logic [SLOTS-1:0]        valid_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    slot_ok_q;
	logic                    hit_valid_q;

	outcome_t                outcome_q;
	logic [ARC_W-1:0]        arc_q;
	logic signed [VAL_W-1:0] smooth_q;
	logic signed [VAL_W-1:0] stored_q;
	logic                    have_if_q;
	logic                    write_q;
	logic                    neg_q;
	logic [ARC_W-1:0]        n_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [ARC_W-1:0]        rem_q;
	logic [$clog2(DVD_W+1)-1:0] div_cnt_q;

	logic                    res_valid_q;
	logic                    res_usable_q;
	outcome_t                res_outcome_q;
	logic signed [VAL_W-1:0] res_smooth_q, res_gf_q, res_ifc_q, res_ifp_q;
	logic [OUT_ARC_W-1:0]    res_arc_q;

	logic                    accept;
	logic [SLOT_W-1:0]       in_slot;
	logic                    in_slot_ok;
	entry_t                  rd_entry, wr_entry;
	logic                    out_free;
	logic                    ram_we;

	logic signed [VAL_W:0]   d_mw, d_gf;
	logic [VAL_W:0]          mag_mw, mag_gf;
	logic                    slip;
	logic                    gap_bad;
	logic [ARC_W-1:0]        n_next;
	logic [ARC_W:0]          rem_shift;
	logic                    qbit;
	logic                    blank;

	assign in_ready   = (state_q == UPD_IDLE);
	assign accept     = in_valid && in_ready;
	assign in_slot_ok = (in_data.gnss_system == SYS_GPS || in_data.gnss_system == SYS_BDS) &&
		(32'(in_data.sat_number) < SAT_SLOTS);
	assign in_slot    = SLOT_W'(in_data.gnss_system[0]) * SLOT_W'(SAT_SLOTS) +
		SLOT_W'(in_data.sat_number);
	assign out_free   = !res_valid_q || res.ready;
	assign ram_we     = (state_q == UPD_WRITE) && out_free && write_q;

	always_comb begin
		wr_entry.tag    = epoch_q;
		wr_entry.arc    = arc_q;
		wr_entry.smooth = smooth_q;
		wr_entry.gf     = item_q.missing ? '0 : item_q.gf;
	end

	gcsd_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (wr_entry),
		.raddr (in_slot),
		.rdata (rd_entry)
	);

	// jump tests against the stored entry
	always_comb begin
		d_mw    = {item_q.mw[VAL_W-1], item_q.mw} - {rd_entry.smooth[VAL_W-1], rd_entry.smooth};
		d_gf    = {item_q.gf[VAL_W-1], item_q.gf} - {rd_entry.gf[VAL_W-1], rd_entry.gf};
		mag_mw  = d_mw[VAL_W] ? (VAL_W+1)'(-d_mw) : (VAL_W+1)'(d_mw);
		mag_gf  = d_gf[VAL_W] ? (VAL_W+1)'(-d_gf) : (VAL_W+1)'(d_gf);
		slip    = (mag_mw > (VAL_W+1)'(cfg.widelane_jump_limit)) ||
			(mag_gf > (VAL_W+1)'(cfg.gf_jump_limit));
		gap_bad = item_q.epoch_gap_ms[GAP_W-1] ||
			(item_q.epoch_gap_ms[GAP_W-2:0] > (GAP_W-1)'(cfg.max_epoch_gap_ms));
		n_next  = (rd_entry.arc == ARC_MAX) ? ARC_MAX : rd_entry.arc + 1'b1;
		rem_shift = {rem_q, dvd_q[DVD_W-1]};
		qbit    = (rem_shift >= {1'b0, n_q});
		blank   = (outcome_q == OUT_MISSING) || (outcome_q == OUT_UNSUPPORTED);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			UPD_IDLE:  if (accept) state_d = UPD_READ;
			UPD_READ: begin
				if (!item_q.missing && slot_ok_q && hit_valid_q &&
					rd_entry.tag == epoch_q - 1'b1 && rd_entry.arc != '0 && !gap_bad && !slip)
					state_d = UPD_DIV;
				else
					state_d = UPD_WRITE;
			end
			UPD_DIV:   if (div_cnt_q == '0) state_d = UPD_MEAN;
			UPD_MEAN:  state_d = UPD_WRITE;
			UPD_WRITE: if (out_free) state_d = UPD_IDLE;
			default:   state_d = UPD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= UPD_IDLE;
			epoch_q     <= '0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_data.first_of_epoch)
				epoch_q <= epoch_q + 1'b1;
			if (ram_we)
				valid_q[slot_q] <= 1'b1;
			if (state_q == UPD_WRITE && out_free)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q      <= in_data;
			slot_q      <= in_slot;
			slot_ok_q   <= in_slot_ok;
			hit_valid_q <= valid_q[in_slot];
		end

		unique case (state_q)
			UPD_READ: begin
				smooth_q  <= item_q.missing ? '0 : item_q.mw;
				stored_q  <= rd_entry.smooth;
				neg_q     <= d_mw[VAL_W];
				n_q       <= n_next;
				dvd_q     <= DVD_W'(mag_mw) + DVD_W'(n_next >> 1);
				rem_q     <= '0;
				div_cnt_q <= ($clog2(DVD_W+1))'(DVD_W - 1);
				// supported slots are written on every path, including missing frequency
				write_q   <= slot_ok_q;
				if (item_q.missing) begin
					outcome_q <= OUT_MISSING;
					arc_q     <= '0;
					have_if_q <= 1'b0;
				end else if (!slot_ok_q) begin
					outcome_q <= OUT_UNSUPPORTED;
					arc_q     <= '0;
					have_if_q <= 1'b0;
				end else if (!hit_valid_q || rd_entry.tag != epoch_q - 1'b1) begin
					outcome_q <= OUT_NEW_SAT;
					arc_q     <= '0;
					have_if_q <= 1'b0;
				end else if (rd_entry.arc == '0) begin
					outcome_q <= OUT_ARC_START;
					arc_q     <= ARC_W'(1);
					have_if_q <= 1'b1;
				end else if (gap_bad) begin
					outcome_q <= OUT_GAP;
					arc_q     <= ARC_W'(1);
					have_if_q <= 1'b0;
				end else if (slip) begin
					outcome_q <= OUT_SLIP;
					arc_q     <= '0;
					have_if_q <= 1'b0;
				end else begin
					outcome_q <= OUT_OK;
					arc_q     <= n_next;
					have_if_q <= 1'b1;
				end
			end
			UPD_DIV: begin
				// restoring division, one quotient bit per cycle
				rem_q     <= qbit ? ARC_W'(rem_shift - {1'b0, n_q}) : rem_shift[ARC_W-1:0];
				dvd_q     <= {dvd_q[DVD_W-2:0], qbit};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			UPD_MEAN: begin
				smooth_q <= neg_q ? stored_q - VAL_W'(dvd_q) : stored_q + VAL_W'(dvd_q);
			end
			default: begin
			end
		endcase

		if (state_q == UPD_WRITE && out_free) begin
			res_outcome_q <= outcome_q;
			res_usable_q  <= (outcome_q == OUT_OK);
			res_smooth_q  <= blank ? '0 : smooth_q;
			res_gf_q      <= blank ? '0 : item_q.gf;
			res_ifc_q     <= (have_if_q && !blank) ? item_q.ifc : '0;
			res_ifp_q     <= (have_if_q && !blank) ? item_q.ifp : '0;
			res_arc_q     <= (32'(arc_q) > 32'hFFFF) ? '1 : OUT_ARC_W'(arc_q);
		end
	end

	assign res.valid               = res_valid_q;
	assign res.usable              = res_usable_q;
	assign res.outcome             = res_outcome_q;
	assign res.smoothed_widelane   = res_smooth_q;
	assign res.geometry_free_phase = res_gf_q;
	assign res.iono_free_code      = res_ifc_q;
	assign res.iono_free_phase     = res_ifp_q;
	assign res.arc_length          = res_arc_q;

`ifndef SYNTHESIS
	a_div_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == UPD_DIV && $past(state_q) != UPD_DIV) |-> $past(state_q) == UPD_READ)
		else $error("divider entered without a table read");
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == UPD_READ)
		else $error("accepted transaction did not start a table read");
	a_unsup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == UPD_WRITE && outcome_q == OUT_UNSUPPORTED) |-> !ram_we)
		else $error("unsupported observation wrote the table");
	a_usable_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.usable == (res.outcome == OUT_OK)))
		else $error("usable flag disagrees with outcome");
`endif

endmodule

FILE: rtl/gnss_cycle_slip_detector.sv
// top level of the gnss melbourne-wubbena / geometry-free cycle-slip detector
//
// obs channel: one dual-frequency observation per transaction, taken when valid and ready.
// res channel: exactly one result per observation, in order, held until taken.
// cfg port: cfg_we writes cfg_data into register cfg_index (0 mw limit, 1 gf limit,
//   2 max epoch gap); write only while no observation is in flight.
// the combination unit forms ten 24x36 products on one multiplier, each operand in two
//   24-bit halves, then rounds and sums; it takes the next observation as soon as its
//   result is loaded into the output register toward the table unit.
// the table unit reads the satellite entry from a 128 x 128 bit ram, classifies, and for
//   a continuing arc runs a restoring divide (21-bit dividend) before write-back; the other
//   paths go from the classification straight to write-back.
// reset clears the epoch counter, the entry valid bits and both channels; the ram itself
//   is not cleared, the valid bits mask its contents.
// a stalled receiver holds the result register; the table unit then waits, and the
//   combination unit keeps one finished observation and one more in work.
module gnss_cycle_slip_detector import gcsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	gcsd_obs_if.sink         obs,
	gcsd_res_if.source       res,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [LIM_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  comb_valid;
	logic  comb_ready;
	comb_t comb_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.widelane_jump_limit <= WL_LIMIT_RESET;
			cfg_q.gf_jump_limit       <= GF_LIMIT_RESET;
			cfg_q.max_epoch_gap_ms    <= MAX_GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WL_LIMIT: cfg_q.widelane_jump_limit <= cfg_data;
				REG_GF_LIMIT: cfg_q.gf_jump_limit       <= cfg_data;
				REG_MAX_GAP:  cfg_q.max_epoch_gap_ms    <= cfg_data[MAXGAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gcsd_comb u_comb (
		.clk        (clk),
		.arst_n     (arst_n),
		.obs        (obs),
		.comb_valid (comb_valid),
		.comb_ready (comb_ready),
		.comb_data  (comb_data)
	);

	gcsd_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comb_valid),
		.in_ready (comb_ready),
		.in_data  (comb_data),
		.cfg      (cfg_q),
		.res      (res)
	);

endmodule
